// ===== rtl/core/pip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the point-in-polygon tester.
// Used by the channel interfaces, the vertex cell, the edge unit and the top level.
package pip_pkg;

   localparam int MaxVertices = 64;
   localparam int CoordBits   = 16;
   localparam int CountBits   = $clog2(MaxVertices + 1);
   localparam int ProdBits    = 2 * CoordBits + 2;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      OUT_DONE      = 2'd0,
      OUT_DUPLICATE = 2'd1,
      OUT_NOT_FOUND = 2'd2,
      OUT_FULL      = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // What a vertex cell loads at the next clock edge.
   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_NEXT,
      SEL_HEAD,
      SEL_NEW
   } cell_sel_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
   } vertex_type;

   // Per-edge verdict from the edge unit.
   typedef struct packed {
      logic hit;      // edge straddles the point's y
      logic on_line;  // point lies exactly on the edge
      logic left;     // crossing lies right of the point
   } edge_result_type;

endpackage

// ===== rtl/core/pip_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one add, delete or query item.
// Depends on pip_pkg for the action type and coordinate width.
interface pip_req_if;
   import pip_pkg::*;

   logic                        valid;
   logic                        ready;
   action_type                  action;
   logic signed [CoordBits-1:0] x_coord;
   logic signed [CoordBits-1:0] y_coord;

   modport source (output valid, output action, output x_coord, output y_coord,
                   input ready);
   modport sink (input valid, input action, input x_coord, input y_coord,
                 output ready);
endinterface

// ===== rtl/core/pip_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result per request.
// Depends on pip_pkg for the outcome type and count width.
interface pip_rsp_if;
   import pip_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 inside_res;
   logic                 on_edge;
   outcome_type          outcome;
   logic [CountBits-1:0] vertex_total;

   modport source (output valid, output inside_res, output on_edge, output outcome,
                   output vertex_total, input ready);
   modport sink (input valid, input inside_res, input on_edge, input outcome,
                 input vertex_total, output ready);
endinterface

// ===== rtl/core/pip_cell.sv =====
`timescale 1ns / 1ps
// One vertex cell of the rotating vertex chain.
// Depends on pip_pkg for the vertex and select types.
module pip_cell (
   input  logic                  clock,
   input  pip_pkg::cell_sel_type ctl,
   input  pip_pkg::vertex_type   nxt,
   input  pip_pkg::vertex_type   head,
   input  pip_pkg::vertex_type   wr,
   output pip_pkg::vertex_type   q
);
   import pip_pkg::*;

   vertex_type vtx_ff;
   vertex_type vtx_in;

   // Load from the neighbor, the chain head (wrap), a new vertex, or hold.
   always_comb begin
      case (ctl)
         SEL_NEXT: vtx_in = nxt;
         SEL_HEAD: vtx_in = head;
         SEL_NEW:  vtx_in = wr;
         default:  vtx_in = vtx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      vtx_ff <= vtx_in;
   end

   assign q = vtx_ff;
endmodule

// ===== rtl/core/pip_edge_unit.sv =====
`timescale 1ns / 1ps
// Two-stage edge test: straddle check and exact cross-multiplied crossing compare.
// Depends on pip_pkg for the vertex and edge result types.
module pip_edge_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     vld,
   input  pip_pkg::vertex_type      pt,
   input  pip_pkg::vertex_type      v1,
   input  pip_pkg::vertex_type      v2,
   output pip_pkg::edge_result_type res
);
   import pip_pkg::*;

   logic signed [CoordBits:0]   dx1, dy1, dxe, dye;
   logic signed [ProdBits-1:0]  lhs_in, rhs_in, lhs_ff, rhs_ff;
   logic                        straddle_in, straddle_ff, dneg_ff, vld_ff;

   // Stage one: differences, straddle test and both products.
   always_comb begin
      dx1         = $signed({pt.x[CoordBits-1], pt.x}) - $signed({v1.x[CoordBits-1], v1.x});
      dy1         = $signed({pt.y[CoordBits-1], pt.y}) - $signed({v1.y[CoordBits-1], v1.y});
      dxe         = $signed({v2.x[CoordBits-1], v2.x}) - $signed({v1.x[CoordBits-1], v1.x});
      dye         = $signed({v2.y[CoordBits-1], v2.y}) - $signed({v1.y[CoordBits-1], v1.y});
      straddle_in = (v1.y > pt.y) != (v2.y > pt.y);
      lhs_in      = dx1 * dye;
      rhs_in      = dy1 * dxe;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld;
      end
      straddle_ff <= straddle_in;
      dneg_ff     <= dye[CoordBits];
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
   end

   // Stage two: the compare flips sense when the edge runs downward.
   always_comb begin
      res.hit     = vld_ff && straddle_ff;
      res.on_line = lhs_ff == rhs_ff;
      res.left    = dneg_ff ? (lhs_ff > rhs_ff) : (lhs_ff < rhs_ff);
   end
endmodule

// ===== rtl/core/point_in_polygon_tester_top.sv =====
`timescale 1ns / 1ps
// Point-in-polygon tester, top level.
// Depends on pip_pkg, pip_req_if, pip_rsp_if, pip_cell and pip_edge_unit.
//
// Usage:
//   req_ch carries one item: action (add, delete, query) and a signed x/y point.
//   rsp_ch returns exactly one result per item: inside_res, on_edge, outcome and
//   the vertex count after the item.
//   The vertices sit in a chain of cells that rotates one place per cycle while
//   an item walks; the head cell feeds the compare logic and the two-stage edge
//   unit. A full rotation over the n stored vertices restores the order.
//   The block takes one item at a time; req_ch.ready is high only when idle.
//   A finished result waits in the output register while the receiver stalls;
//   the next item may be taken meanwhile, and its result is held back until
//   the earlier one has transferred.
//   Reset (synchronous) empties the table and clears any pending result.
module point_in_polygon_tester_top (
   input logic      clock,
   input logic      reset,
   pip_req_if.sink  req_ch,
   pip_rsp_if.source rsp_ch
);
   import pip_pkg::*;

   state_type            state_ff, state_in;
   action_type           act_ff, act_in;
   vertex_type           pt_ff, pt_in, first_ff, first_in;
   logic [CountBits-1:0] rem_ff, rem_in, n_ff, n_in;
   logic                 dup_ff, dup_in, found_ff, found_in;
   logic                 edge_ff, edge_in, par_ff, par_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_inside_ff, rsp_inside_in, rsp_edge_ff, rsp_edge_in;
   outcome_type          rsp_outcome_ff, rsp_outcome_in;
   logic [CountBits-1:0] rsp_total_ff, rsp_total_in;

   vertex_type           cell_q [MaxVertices];
   cell_sel_type         cell_ctl [MaxVertices];
   vertex_type           edge_v2;
   edge_result_type      eres;

   logic                 accept, walking, match, discard, out_free, commit;

   assign accept   = req_ch.valid && req_ch.ready;
   assign walking  = (state_ff == ST_WALK) && (rem_ff != '0);
   assign match    = cell_q[0] == pt_ff;
   assign discard  = walking && (act_ff == ACT_DELETE) && match && !found_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign commit   = (state_ff == ST_FINISH) && out_free && (act_ff == ACT_ADD) &&
                     !dup_ff && (n_ff < CountBits'(MaxVertices));

   // Vertex chain with per-cell load select.
   for (genvar i = 0; i < MaxVertices; i++) begin : g_cell
      vertex_type nxt;
      if (i < MaxVertices - 1) begin : g_mid
         assign nxt = cell_q[i+1];
      end else begin : g_last
         assign nxt = cell_q[0];
      end

      always_comb begin
         cell_ctl[i] = SEL_HOLD;
         if (discard) begin
            if (CountBits'(i + 1) < n_ff) cell_ctl[i] = SEL_NEXT;
         end else if (walking) begin
            if (CountBits'(i + 1) < n_ff) cell_ctl[i] = SEL_NEXT;
            else if (CountBits'(i + 1) == n_ff) cell_ctl[i] = SEL_HEAD;
         end else if (commit && (CountBits'(i) == n_ff)) begin
            cell_ctl[i] = SEL_NEW;
         end
      end

      pip_cell u_cell (
         .clock (clock),
         .ctl   (cell_ctl[i]),
         .nxt   (nxt),
         .head  (cell_q[0]),
         .wr    (pt_ff),
         .q     (cell_q[i])
      );
   end

   // The closing edge joins the last vertex back to the first.
   assign edge_v2 = (rem_ff == CountBits'(1)) ? first_ff : cell_q[1];

   pip_edge_unit u_edge (
      .clock (clock),
      .reset (reset),
      .vld   (walking && (act_ff == ACT_QUERY)),
      .pt    (pt_ff),
      .v1    (cell_q[0]),
      .v2    (edge_v2),
      .res   (eres)
   );

   // Next state, walk bookkeeping and result formation.
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      pt_in          = pt_ff;
      first_in       = first_ff;
      rem_in         = rem_ff;
      n_in           = n_ff;
      dup_in         = dup_ff;
      found_in       = found_ff;
      edge_in        = edge_ff;
      par_in         = par_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_inside_in  = rsp_inside_ff;
      rsp_edge_in    = rsp_edge_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_total_in   = rsp_total_ff;

      // Edge verdicts arrive in the cycle after the edge leaves the head.
      if (eres.hit) begin
         if (eres.on_line) edge_in = 1'b1;
         else if (eres.left) par_in = !par_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_ch.action;
               pt_in.x  = req_ch.x_coord;
               pt_in.y  = req_ch.y_coord;
               first_in = cell_q[0];
               rem_in   = n_ff;
               dup_in   = 1'b0;
               found_in = 1'b0;
               edge_in  = 1'b0;
               par_in   = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walking) begin
               rem_in = rem_ff - CountBits'(1);
               if ((act_ff == ACT_ADD) && match) dup_in = 1'b1;
               if (discard) begin
                  found_in = 1'b1;
                  n_in     = n_ff - CountBits'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_inside_in  = (act_ff == ACT_QUERY) && (edge_ff || par_ff);
               rsp_edge_in    = (act_ff == ACT_QUERY) && edge_ff;
               rsp_outcome_in = OUT_DONE;
               rsp_total_in   = n_ff;
               if (act_ff == ACT_ADD) begin
                  if (dup_ff) rsp_outcome_in = OUT_DUPLICATE;
                  else if (!commit) rsp_outcome_in = OUT_FULL;
               end else if ((act_ff == ACT_DELETE) && !found_ff) begin
                  rsp_outcome_in = OUT_NOT_FOUND;
               end
               if (commit) begin
                  n_in         = n_ff + CountBits'(1);
                  rsp_total_in = n_ff + CountBits'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      pt_ff          <= pt_in;
      first_ff       <= first_in;
      rem_ff         <= rem_in;
      dup_ff         <= dup_in;
      found_ff       <= found_in;
      edge_ff        <= edge_in;
      par_ff         <= par_in;
      rsp_inside_ff  <= rsp_inside_in;
      rsp_edge_ff    <= rsp_edge_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign req_ch.ready        = state_ff == ST_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.inside_res   = rsp_inside_ff;
   assign rsp_ch.on_edge      = rsp_edge_ff;
   assign rsp_ch.outcome      = rsp_outcome_ff;
   assign rsp_ch.vertex_total = rsp_total_ff;
endmodule
